FILE: hdl/shash_pkg.sv
// Shared types, constants and functions for the SHA-256 stream hasher.
// No dependencies; imported by shash_core, the top level and the testbench.
`timescale 1ns / 1ps

package shash_pkg;

  typedef logic [31:0] word_t;
  typedef logic [7:0][31:0] hash_t;

  localparam logic [7:0]  PAD_BYTE    = 8'h80;
  localparam int          BLOCK_BITS  = 512;
  localparam int          LEN_OFFSET  = 56;
  localparam int          BLOCK_WORDS = BLOCK_BITS / 32;
  localparam logic [3:0]  LEN_HI_SLOT = 4'(LEN_OFFSET / 4);
  localparam logic [3:0]  LAST_SLOT   = 4'(BLOCK_WORDS - 1);
  localparam logic [5:0]  LAST_ROUND  = 6'd63;
  localparam logic [2:0]  LAST_INDEX  = 3'd7;
  localparam logic [2:0]  FULL_BYTES  = 3'd4;

  localparam hash_t INIT_HASH = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  // Control from the sequencer to the compression unit
  typedef struct packed {
    logic push;   // shift push_word into the schedule window
    logic start;  // begin 64 rounds on the current window
    logic rearm;  // return the chaining value to the initial hash
  } core_ctl_t;

  typedef struct packed {
    logic busy;   // rounds or final add in progress
    logic done;   // chaining value updated this cycle
  } core_sts_t;

  function automatic word_t rotr(input word_t x, input int n);
    rotr = (x >> n) | (x << (32 - n));
  endfunction

  function automatic word_t big_s0(input word_t x);
    big_s0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
  endfunction

  function automatic word_t big_s1(input word_t x);
    big_s1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
  endfunction

  function automatic word_t small_s0(input word_t x);
    small_s0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
  endfunction

  function automatic word_t small_s1(input word_t x);
    small_s1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    case (idx)
      6'd0:  round_k = 32'h428a2f98;  6'd1:  round_k = 32'h71374491;
      6'd2:  round_k = 32'hb5c0fbcf;  6'd3:  round_k = 32'he9b5dba5;
      6'd4:  round_k = 32'h3956c25b;  6'd5:  round_k = 32'h59f111f1;
      6'd6:  round_k = 32'h923f82a4;  6'd7:  round_k = 32'hab1c5ed5;
      6'd8:  round_k = 32'hd807aa98;  6'd9:  round_k = 32'h12835b01;
      6'd10: round_k = 32'h243185be;  6'd11: round_k = 32'h550c7dc3;
      6'd12: round_k = 32'h72be5d74;  6'd13: round_k = 32'h80deb1fe;
      6'd14: round_k = 32'h9bdc06a7;  6'd15: round_k = 32'hc19bf174;
      6'd16: round_k = 32'he49b69c1;  6'd17: round_k = 32'hefbe4786;
      6'd18: round_k = 32'h0fc19dc6;  6'd19: round_k = 32'h240ca1cc;
      6'd20: round_k = 32'h2de92c6f;  6'd21: round_k = 32'h4a7484aa;
      6'd22: round_k = 32'h5cb0a9dc;  6'd23: round_k = 32'h76f988da;
      6'd24: round_k = 32'h983e5152;  6'd25: round_k = 32'ha831c66d;
      6'd26: round_k = 32'hb00327c8;  6'd27: round_k = 32'hbf597fc7;
      6'd28: round_k = 32'hc6e00bf3;  6'd29: round_k = 32'hd5a79147;
      6'd30: round_k = 32'h06ca6351;  6'd31: round_k = 32'h14292967;
      6'd32: round_k = 32'h27b70a85;  6'd33: round_k = 32'h2e1b2138;
      6'd34: round_k = 32'h4d2c6dfc;  6'd35: round_k = 32'h53380d13;
      6'd36: round_k = 32'h650a7354;  6'd37: round_k = 32'h766a0abb;
      6'd38: round_k = 32'h81c2c92e;  6'd39: round_k = 32'h92722c85;
      6'd40: round_k = 32'ha2bfe8a1;  6'd41: round_k = 32'ha81a664b;
      6'd42: round_k = 32'hc24b8b70;  6'd43: round_k = 32'hc76c51a3;
      6'd44: round_k = 32'hd192e819;  6'd45: round_k = 32'hd6990624;
      6'd46: round_k = 32'hf40e3585;  6'd47: round_k = 32'h106aa070;
      6'd48: round_k = 32'h19a4c116;  6'd49: round_k = 32'h1e376c08;
      6'd50: round_k = 32'h2748774c;  6'd51: round_k = 32'h34b0bcb5;
      6'd52: round_k = 32'h391c0cb3;  6'd53: round_k = 32'h4ed8aa4a;
      6'd54: round_k = 32'h5b9cca4f;  6'd55: round_k = 32'h682e6ff3;
      6'd56: round_k = 32'h748f82ee;  6'd57: round_k = 32'h78a5636f;
      6'd58: round_k = 32'h84c87814;  6'd59: round_k = 32'h8cc70208;
      6'd60: round_k = 32'h90befffa;  6'd61: round_k = 32'ha4506ceb;
      6'd62: round_k = 32'hbef9a3f7;  6'd63: round_k = 32'hc67178f2;
      default: round_k = 32'h0;
    endcase
  endfunction

endpackage

FILE: hdl/shash_core.sv
// SHA-256 compression unit: schedule window, working variables, chaining value.
// One round per cycle on a single shared round datapath. Depends on shash_pkg.
`timescale 1ns / 1ps

module shash_core import shash_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  core_ctl_t ctl,
  input  word_t     push_word,
  output core_sts_t sts,
  output hash_t     chain
);

  typedef enum logic [2:0] {
    C_IDLE  = 3'b001,
    C_ROUND = 3'b010,
    C_FIN   = 3'b100
  } core_state_t;

  core_state_t state_r, state_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  hash_t       chain_r, chain_nxt;
  hash_t       work_r, work_nxt;
  logic [15:0][31:0] win_r, win_nxt;

  word_t t1, t2, w_new;

  always_comb begin
    t1    = work_r[7] + big_s1(work_r[4])
          + ((work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]))
          + round_k(rnd_r) + win_r[0];
    t2    = big_s0(work_r[0])
          + ((work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]));
    w_new = small_s1(win_r[14]) + win_r[9] + small_s0(win_r[1]) + win_r[0];
  end

  always_comb begin
    state_nxt = state_r;
    rnd_nxt   = rnd_r;
    chain_nxt = chain_r;
    work_nxt  = work_r;
    win_nxt   = win_r;
    case (state_r)
      C_IDLE: begin
        if (ctl.push) begin
          win_nxt = {push_word, win_r[15:1]};
        end
        if (ctl.rearm) begin
          chain_nxt = INIT_HASH;
        end
        if (ctl.start) begin
          work_nxt  = chain_r;
          rnd_nxt   = '0;
          state_nxt = C_ROUND;
        end
      end
      C_ROUND: begin
        // advance the window; the word leaving slot 0 feeds this round
        win_nxt  = {w_new, win_r[15:1]};
        work_nxt = {work_r[6:4], work_r[3] + t1, work_r[2:0], t1 + t2};
        rnd_nxt  = rnd_r + 6'd1;
        if (rnd_r == LAST_ROUND) begin
          state_nxt = C_FIN;
        end
      end
      C_FIN: begin
        for (int i = 0; i < 8; i++) begin
          chain_nxt[i] = chain_r[i] + work_r[i];
        end
        state_nxt = C_IDLE;
      end
      default: state_nxt = C_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= C_IDLE;
      rnd_r   <= '0;
      chain_r <= INIT_HASH;
    end else begin
      state_r <= state_nxt;
      rnd_r   <= rnd_nxt;
      chain_r <= chain_nxt;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
    win_r  <= win_nxt;
  end

  assign sts.busy = (state_r != C_IDLE);
  assign sts.done = (state_r == C_FIN);
  assign chain    = chain_r;

endmodule

FILE: hdl/sha256_stream_hasher.sv
// Top level of the SHA-256 stream hasher: input sequencer, padding, digest output.
// Depends on shash_pkg and shash_core.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_*): one big-endian 32-bit message word per handshake,
//   first byte in bits 31:24. in_tdata[34:32] gives the valid leading bytes,
//   read only on the word with in_tlast high (values above four count as four).
//   Output channel (out_*): eight digest words per message, index 0 first,
//   out_tlast on index 7.
//   Throughput: words that close neither a block nor the message are taken one
//   per cycle; the word that closes a 512-bit block starts the shared round
//   unit, which runs one round per cycle, and in_tready stays low through the
//   64 rounds and the chaining add.
//   After the last word: the padding words are pushed one per cycle, with one
//   or two compressions (two when the length spills into an extra block), then
//   the digest leaves one word per cycle while out_tready stays high.
//   Reset (rst_n low, synchronous) loads the initial hash, clears the bit count
//   and empties the output register.
//   Stall: the digest sits in an output register; while the receiver holds
//   out_tready low the word holds. The last digest word may still wait there
//   while the next message's first word is taken.

module sha256_stream_hasher import shash_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [39:0] in_tdata,   // [31:0] data_word, [34:32] bytes_valid, [39:35] zero
  input  logic        in_tlast,   // last_word
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [31:0] digest_word, [34:32] word_index, [39:35] zero
  output logic        out_tlast   // last_of_digest
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PAD  = 4'b0010,
    S_COMP = 4'b0100,
    S_OUT  = 4'b1000
  } seq_state_t;

  seq_state_t  state_r, state_nxt;
  logic [3:0]  wib_r, wib_nxt;        // words held in the current block
  logic [63:0] bitlen_r, bitlen_nxt;  // message length in bits, wraps
  logic        need80_r, need80_nxt;  // a full pad word is still owed
  logic        lenhi_r, lenhi_nxt;    // high length word already pushed
  logic        pad_r, pad_nxt;        // padding sequence under way
  logic        fin_r, fin_nxt;        // final block handed to the core
  logic [2:0]  oidx_r, oidx_nxt;
  logic        ovalid_r, ovalid_nxt;
  word_t       oword_r, oword_nxt;
  logic [2:0]  oindex_r, oindex_nxt;
  logic        olast_r, olast_nxt;

  core_ctl_t ctl;
  core_sts_t sts;
  word_t     push_word;
  hash_t     chain;

  word_t      in_word;
  logic [2:0] in_bytes;
  logic [2:0] nbytes;
  word_t      keep;
  word_t      pad_word;
  logic       in_acc;
  logic       out_load;

  assign in_word  = in_tdata[31:0];
  assign in_bytes = in_tdata[34:32];
  assign in_acc   = in_tvalid && in_tready;
  assign nbytes   = (in_bytes > FULL_BYTES) ? FULL_BYTES : in_bytes;

  // keep the valid leading bytes, drop the rest and, for a partial word, place the pad byte after them
  always_comb begin
    case (nbytes)
      3'd0:    begin keep = 32'h0000_0000; pad_word = {PAD_BYTE, 24'h0};        end
      3'd1:    begin keep = 32'hff00_0000; pad_word = {8'h0, PAD_BYTE, 16'h0};  end
      3'd2:    begin keep = 32'hffff_0000; pad_word = {16'h0, PAD_BYTE, 8'h0};  end
      3'd3:    begin keep = 32'hffff_ff00; pad_word = {24'h0, PAD_BYTE};        end
      default: begin keep = 32'hffff_ffff; pad_word = 32'h0;                    end
    endcase
  end

  always_comb begin
    state_nxt  = state_r;
    wib_nxt    = wib_r;
    bitlen_nxt = bitlen_r;
    need80_nxt = need80_r;
    lenhi_nxt  = lenhi_r;
    pad_nxt    = pad_r;
    fin_nxt    = fin_r;
    oidx_nxt   = oidx_r;
    ctl        = '0;
    push_word  = '0;
    out_load   = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          ctl.push = 1'b1;
          wib_nxt  = wib_r + 4'd1;
          if (!in_tlast) begin
            push_word  = in_word;
            bitlen_nxt = bitlen_r + 64'd32;
          end else begin
            push_word  = (in_word & keep) | pad_word;
            bitlen_nxt = bitlen_r + {58'd0, nbytes, 3'd0};
            need80_nxt = (nbytes == FULL_BYTES);
            pad_nxt    = 1'b1;
          end
          if (wib_r == LAST_SLOT) begin
            ctl.start = 1'b1;
            state_nxt = S_COMP;
          end else if (in_tlast) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        ctl.push = 1'b1;
        wib_nxt  = wib_r + 4'd1;
        if (need80_r) begin
          push_word  = {PAD_BYTE, 24'h0};
          need80_nxt = 1'b0;
        end else if (lenhi_r) begin
          push_word = bitlen_r[31:0];
          fin_nxt   = 1'b1;
        end else if (wib_r == LEN_HI_SLOT) begin
          push_word = bitlen_r[63:32];
          lenhi_nxt = 1'b1;
        end
        if (wib_r == LAST_SLOT) begin
          ctl.start = 1'b1;
          state_nxt = S_COMP;
        end
      end
      S_COMP: begin
        if (sts.done) begin
          oidx_nxt = '0;
          if (fin_r) begin
            state_nxt = S_OUT;
          end else if (pad_r) begin
            state_nxt = S_PAD;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_OUT: begin
        if (!ovalid_r || out_tready) begin
          out_load = 1'b1;
          oidx_nxt = oidx_r + 3'd1;
          if (oidx_r == LAST_INDEX) begin
            // digest captured; rearm for the next message
            ctl.rearm  = 1'b1;
            bitlen_nxt = '0;
            wib_nxt    = '0;
            pad_nxt    = 1'b0;
            fin_nxt    = 1'b0;
            lenhi_nxt  = 1'b0;
            need80_nxt = 1'b0;
            state_nxt  = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // output register: load a digest word, drop valid once taken
  always_comb begin
    ovalid_nxt = ovalid_r;
    oword_nxt  = oword_r;
    oindex_nxt = oindex_r;
    olast_nxt  = olast_r;
    if (out_load) begin
      ovalid_nxt = 1'b1;
      oword_nxt  = chain[oidx_r];
      oindex_nxt = oidx_r;
      olast_nxt  = (oidx_r == LAST_INDEX);
    end else if (out_tready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      wib_r    <= '0;
      bitlen_r <= '0;
      need80_r <= 1'b0;
      lenhi_r  <= 1'b0;
      pad_r    <= 1'b0;
      fin_r    <= 1'b0;
      oidx_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      wib_r    <= wib_nxt;
      bitlen_r <= bitlen_nxt;
      need80_r <= need80_nxt;
      lenhi_r  <= lenhi_nxt;
      pad_r    <= pad_nxt;
      fin_r    <= fin_nxt;
      oidx_r   <= oidx_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    oword_r  <= oword_nxt;
    oindex_r <= oindex_nxt;
    olast_r  <= olast_nxt;
  end

  shash_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .push_word (push_word),
    .sts       (sts),
    .chain     (chain)
  );

  assign in_tready  = (state_r == S_IDLE) && !sts.busy;
  assign out_tvalid = ovalid_r;
  assign out_tdata  = {5'd0, oindex_r, oword_r};
  assign out_tlast  = olast_r;

endmodule

FILE: hdl/shash_checker.sv
// Port-level checks for the SHA-256 stream hasher, bound to the top level.
// Depends on sha256_stream_hasher's ports only.
`timescale 1ns / 1ps

module shash_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic        in_tlast,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tlast
);

  // a stalled digest word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tlast))
    else $error("digest word changed under stall");

  // the last mark sits exactly on index seven
  a_last_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tlast == (out_tdata[34:32] == 3'd7)))
    else $error("last mark and word index disagree");

  // reset empties the output register
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("output valid after reset");

  // the final word starts padding or a compression, so the input closes
  a_last_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tlast |=> !in_tready)
    else $error("input open right after last word");

endmodule

bind sha256_stream_hasher shash_checker u_shash_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .in_tlast   (in_tlast),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tlast  (out_tlast)
);

FILE: dv/tb_sha256_stream_hasher.sv
// Self-checking testbench for sha256_stream_hasher: drives messages as stream words
// and checks every digest word against an in-bench SHA-256 hash tracker.
// Depends on shash_pkg (word type) and the sha256_stream_hasher RTL.
`timescale 1ns / 1ps

module tb_sha256_stream_hasher;
  import shash_pkg::word_t;

  localparam int    IDLE_PCT     = 14;    // chance in a hundred that a side idles in a cycle
  localparam int    RANDOM_WORDS = 460;   // message words in the random part
  localparam int    STEADY_FROM  = 180;   // words sent when the no-idle stretch begins
  localparam int    STEADY_TO    = 300;   // words sent when it ends
  localparam int    HANG_LIMIT   = 3000;  // cycles with no handshake before giving up
  localparam int    TAIL_CYCLES  = 200;   // settle time after the last digest word
  localparam int    LEN_SLOT     = 14;    // slot of the high length word in a block
  localparam int    FULL_WORD    = 4;     // bytes in a full message word
  localparam int    LAST_POS     = 7;     // index of the final digest word
  localparam word_t PAD_WORD     = 32'h8000_0000;

  localparam word_t HASH_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
  };

  localparam word_t ROUND_K [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  // One expected digest word as it should leave the output channel
  typedef struct packed {
    word_t      value;
    logic [2:0] index;
    logic       final_word;
  } digest_word_t;

  // Tracks the running hash of the message in flight and holds the digest
  // words still owed by the block, oldest first.
  class sha256_hash_tracker;
    word_t          chain [8];
    word_t          block_words [16];
    logic [63:0]    bit_count;
    int             words_in_block;
    digest_word_t   digest_words [$];
    int unsigned    err_count;

    function new();
      rearm();
      err_count = 0;
    endfunction

    function void rearm();
      for (int i = 0; i < 8; i++) chain[i] = HASH_INIT[i];
      bit_count      = '0;
      words_in_block = 0;
    endfunction

    function word_t ror(word_t x, int n);
      return (x >> n) | (x << (32 - n));
    endfunction

    function void compress();
      word_t sched [64];
      word_t v [8];
      word_t t1, t2, s0, s1, ch, maj;
      for (int i = 0; i < 16; i++) sched[i] = block_words[i];
      for (int i = 16; i < 64; i++) begin
        s0 = ror(sched[i-15], 7) ^ ror(sched[i-15], 18) ^ (sched[i-15] >> 3);
        s1 = ror(sched[i-2], 17) ^ ror(sched[i-2], 19) ^ (sched[i-2] >> 10);
        sched[i] = s1 + sched[i-7] + s0 + sched[i-16];
      end
      for (int i = 0; i < 8; i++) v[i] = chain[i];
      for (int r = 0; r < 64; r++) begin
        s1  = ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25);
        ch  = (v[4] & v[5]) ^ (~v[4] & v[6]);
        t1  = v[7] + s1 + ch + ROUND_K[r] + sched[r];
        s0  = ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22);
        maj = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
        t2  = s0 + maj;
        v[7] = v[6];
        v[6] = v[5];
        v[5] = v[4];
        v[4] = v[3] + t1;
        v[3] = v[2];
        v[2] = v[1];
        v[1] = v[0];
        v[0] = t1 + t2;
      end
      for (int i = 0; i < 8; i++) chain[i] = chain[i] + v[i];
    endfunction

    function void load(word_t w);
      block_words[words_in_block] = w;
      words_in_block++;
      if (words_in_block == 16) begin
        words_in_block = 0;
        compress();
      end
    endfunction

    // Note one accepted input word; a last word pads, closes the message
    // and queues its eight digest words.
    function void absorb_word(word_t data, logic [2:0] nbytes, logic last);
      int    n;
      word_t keep;
      digest_word_t d;
      if (!last) begin
        load(data);
        bit_count += 64'd32;
        return;
      end
      n = (nbytes > FULL_WORD) ? FULL_WORD : int'(nbytes);
      bit_count += 64'(n * 8);
      if (n == FULL_WORD) begin
        load(data);
        load(PAD_WORD);
      end else begin
        keep = (n == 0) ? 32'h0 : (32'hffff_ffff << (32 - 8 * n));
        load((data & keep) | (PAD_WORD >> (8 * n)));
      end
      while (words_in_block != LEN_SLOT) load(32'h0);
      load(bit_count[63:32]);
      load(bit_count[31:0]);
      for (int i = 0; i < 8; i++) begin
        d.value      = chain[i];
        d.index      = 3'(i);
        d.final_word = (i == LAST_POS);
        digest_words.push_back(d);
      end
      rearm();
    endfunction

    task flag_mismatch(string msg);
      $display("MISMATCH at %0t: %s", $realtime, msg);
      err_count++;
    endtask

    // Check one digest word taken from the output channel
    task match_digest_word(word_t value, logic [2:0] index, logic final_word);
      digest_word_t d;
      if (digest_words.size() == 0) begin
        flag_mismatch($sformatf("digest word %h idx %0d with nothing outstanding",
                                value, index));
        return;
      end
      d = digest_words.pop_front();
      if (value !== d.value)
        flag_mismatch($sformatf("idx %0d digest_word %h, want %h", d.index, value, d.value));
      if (index !== d.index)
        flag_mismatch($sformatf("word_index %0d, want %0d", index, d.index));
      if (final_word !== d.final_word)
        flag_mismatch($sformatf("idx %0d last_of_digest %b, want %b",
                                d.index, final_word, d.final_word));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [39:0] in_tdata = '0;    // [31:0] data_word, [34:32] bytes_valid, [39:35] zero
  logic        in_tlast = 1'b0;  // last_word
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;        // [31:0] digest_word, [34:32] word_index, [39:35] zero
  logic        out_tlast;        // last_of_digest

  sha256_hash_tracker tracker = new();
  bit steady = 1'b0;  // when set, neither side idles

  sha256_stream_hasher uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Receiver: stall at random outside the steady stretch
  always @(posedge clk) begin
    if (steady) begin
      out_tready <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Output monitor: every accepted word goes to the tracker
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      tracker.match_digest_word(out_tdata[31:0], out_tdata[34:32], out_tlast);
  end

  // Watchdog: give up after too long without any handshake
  initial begin : hang_watch
    int quiet;
    quiet = 0;
    while (quiet < HANG_LIMIT) begin
      @(posedge clk);
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) quiet = 0;
      else quiet++;
    end
    $display("TIMEOUT: no handshake for %0d cycles", HANG_LIMIT);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // Offer one word and hold it until taken. Leave tvalid high afterwards so
  // back-to-back words never drop it between them.
  task automatic send_word(input word_t data, input logic [2:0] nbytes, input logic last);
    if (!steady) begin
      while ($urandom_range(99) < IDLE_PCT) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {5'b0, nbytes, data};
    in_tlast  <= last;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    tracker.absorb_word(data, nbytes, last);
  endtask

  // Drop tvalid and hold off until every owed digest word has come out
  task automatic drain_digests();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (tracker.digest_words.size() != 0);
  endtask

  // A message of random words; byte counts on inner words are random too,
  // since the block must ignore them.
  task automatic send_message(input int len);
    word_t data;
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(9))
        0:       data = 32'hffff_ffff;
        1:       data = 32'h0;
        default: data = $urandom;
      endcase
      send_word(data, 3'($urandom_range(7)), k == len - 1);
    end
  endtask

  initial begin : stimulus
    int sent;
    int len;
    int pick;

    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty message, partial last words with junk past the valid bytes,
    // and byte counts above four
    send_word(32'hffff_ffff, 3'd0, 1'b1);
    send_word(32'hffff_ffff, 3'd1, 1'b1);
    send_word(32'hffff_ffff, 3'd2, 1'b1);
    send_word(32'hffff_ffff, 3'd3, 1'b1);
    send_word(32'hffff_ffff, 3'd4, 1'b1);
    send_word(32'h0123_4567, 3'd5, 1'b1);
    send_word(32'h89ab_cdef, 3'd6, 1'b1);
    send_word(32'h0000_0000, 3'd7, 1'b1);
    // Zero byte count on an inner word must still count four bytes
    send_word(32'h0000_0000, 3'd0, 1'b0);
    send_word(32'hffff_ffff, 3'd4, 1'b1);
    // Full last word landing at slot 13: length no longer fits, extra block
    for (int k = 0; k < 13; k++)
      send_word($urandom, 3'(k % 8), 1'b0);
    send_word(32'hdead_beef, 3'd4, 1'b1);

    // Hold the sender until the block has delivered every digest word
    drain_digests();

    sent = 0;
    while (sent < RANDOM_WORDS) begin
      steady = (sent >= STEADY_FROM) && (sent < STEADY_TO);
      pick = $urandom_range(99);
      // Favor lengths around block boundaries, where padding spills over
      if (pick < 35)      len = $urandom_range(1, 6);
      else if (pick < 65) len = $urandom_range(12, 18);
      else if (pick < 85) len = $urandom_range(28, 34);
      else                len = $urandom_range(1, 48);
      send_message(len);
      sent += len;
      if ($urandom_range(7) == 0) drain_digests();
    end
    steady = 1'b0;

    drain_digests();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (tracker.err_count == 0 && tracker.digest_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/shash_pkg.sv
hdl/shash_core.sv
hdl/sha256_stream_hasher.sv
hdl/shash_checker.sv
dv/tb_sha256_stream_hasher.sv
